>>> rtl/core/bls_pkg.sv
// shared constants, codes and controller/datapath interface types for the list stack engine
`timescale 1ns / 1ps
`default_nettype none

package bls_pkg;

   // storage geometry
   localparam int DEPTH     = 64;
   localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W     = $clog2(DEPTH + 1);

   // fixed field widths
   localparam int DATA_W    = 32;
   localparam int KIND_W    = 3;
   localparam int POS_W     = 6;
   localparam int STATUS_W  = 2;
   localparam int OUT_CNT_W = 7;
   localparam int CMP_W     = (POS_W > CNT_W) ? POS_W : CNT_W;

   // request kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH   = 3'd0,
      KIND_POP    = 3'd1,
      KIND_SEARCH = 3'd2,
      KIND_CLEAR  = 3'd3,
      KIND_SUM    = 3'd4,
      KIND_DELETE = 3'd5
   } kind_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   // controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_POP_TAKE,
      S_SCAN,
      S_DEL_HEAD,
      S_DEL_SHIFT,
      S_FINISH
   } state_type;

   // read address source
   typedef enum logic [1:0] {
      RD_HEAD,
      RD_DEL,
      RD_PTR
   } rd_sel_type;

   // commands from controller to datapath
   typedef struct packed {
      logic       latch_req;
      logic       start;
      status_type status;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       ptr_zero;
      logic       ptr_del;
      logic       ptr_inc;
      logic       acc_en;
      logic       take_rdata;
      logic       wr_push;
      logic       wr_shift;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       cnt_clr;
      logic       load_out;
   } dp_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      kind_type kind;
      logic     empty;
      logic     full;
      logic     pos_bad;
      logic     ptr_first;
      logic     ptr_end;
   } dp_sts_type;

endpackage

`default_nettype wire

>>> rtl/core/bounded_list_stack_engine.sv
// top level of the bounded list stack engine: controller, datapath and checks
`timescale 1ns / 1ps
`default_nettype none

// channel    | valid      | stall      | payload
// -----------+------------+------------+----------------------------------------------
// request    | req_valid  | req_stall  | req_kind, req_value, req_position
// response   | rsp_valid  | rsp_stall  | rsp_result_value, rsp_found, rsp_status,
//            |            |            | rsp_entry_count
//
// push, clear, errors and unused kinds go from decode straight to the finish state; pop reads the head first
// search and sum walk every entry, one memory read per cycle, and skip the walk when empty
// delete reads the entry at the given position from the top, then the close-up copies one entry per cycle
// reset clears the entry count and handshake state only; the entry memory is left as is
// one request is in work at a time; the next is taken as soon as the last one sits in the
// response register, and a stalled response holds the engine in its final state

module bounded_list_stack_engine (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [bls_pkg::KIND_W-1:0]     req_kind,
   input  wire logic signed [bls_pkg::DATA_W-1:0] req_value,
   input  wire logic [bls_pkg::POS_W-1:0]      req_position,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic signed [bls_pkg::DATA_W-1:0]   rsp_result_value,
   output logic                                rsp_found,
   output logic [bls_pkg::STATUS_W-1:0]        rsp_status,
   output logic [bls_pkg::OUT_CNT_W-1:0]       rsp_entry_count
);
   import bls_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   // sequencer
   bls_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // storage and arithmetic
   bls_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_kind         (req_kind),
      .req_value        (req_value),
      .req_position     (req_position),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_result_value (rsp_result_value),
      .rsp_found        (rsp_found),
      .rsp_status       (rsp_status),
      .rsp_entry_count  (rsp_entry_count)
   );

   // an accepted request keeps the engine busy in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("engine idle right after taking a request");

   // a full status only comes from a store at its depth
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> (rsp_entry_count == OUT_CNT_W'(DEPTH)))
      else $error("full status with store below depth");

   // an empty status leaves no entries and no value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EMPTY)
         |-> (rsp_entry_count == '0 && rsp_result_value == '0))
      else $error("empty status with entries or value");

   // a search hit reports ok with a zero value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_status == ST_OK && rsp_result_value == '0))
      else $error("search hit with bad status or value");

   // the entry count never passes the depth
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_count <= OUT_CNT_W'(DEPTH)))
      else $error("entry count beyond depth");

endmodule

`default_nettype wire

>>> rtl/core/bls_datapath.sv
// datapath: entry memory, count, walk pointers, accumulator and result register
`timescale 1ns / 1ps
`default_nettype none

module bls_datapath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [bls_pkg::KIND_W-1:0]     req_kind,
   input  wire logic signed [bls_pkg::DATA_W-1:0] req_value,
   input  wire logic [bls_pkg::POS_W-1:0]      req_position,
   input  wire bls_pkg::dp_cmd_type            cmd,
   output bls_pkg::dp_sts_type                 sts,
   output logic signed [bls_pkg::DATA_W-1:0]   rsp_result_value,
   output logic                                rsp_found,
   output logic [bls_pkg::STATUS_W-1:0]        rsp_status,
   output logic [bls_pkg::OUT_CNT_W-1:0]       rsp_entry_count
);
   import bls_pkg::*;

   // entry memory, oldest entry at address zero
   logic [DATA_W-1:0] entries_ff [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   // request fields held for the whole operation
   logic [KIND_W-1:0] kind_ff;
   logic [DATA_W-1:0] value_ff;
   logic [POS_W-1:0]  position_ff;

   // control state
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic [ADDR_W-1:0] dst_ff, dst_in;

   // working result
   logic [DATA_W-1:0] res_ff, res_in;
   logic              found_ff, found_in;
   status_type        status_ff, status_in;

   // output register
   logic [DATA_W-1:0]    out_value_ff;
   logic                 out_found_ff;
   status_type           out_status_ff;
   logic [OUT_CNT_W-1:0] out_count_ff;

   // address arithmetic
   logic [CNT_W-1:0]  head_idx_w;
   logic [CNT_W-1:0]  del_idx_w;
   logic [ADDR_W-1:0] raddr_w;
   logic [ADDR_W-1:0] waddr_w;
   logic              wr_en_w;
   logic [DATA_W-1:0] wdata_w;

   assign head_idx_w = count_ff - CNT_W'(1);
   assign del_idx_w  = count_ff - CNT_W'(1) - CNT_W'(position_ff);

   // status towards the controller
   assign sts.kind      = kind_type'(kind_ff);
   assign sts.empty     = (count_ff == '0);
   assign sts.full      = (count_ff == CNT_W'(DEPTH));
   assign sts.pos_bad   = (CMP_W'(position_ff) >= CMP_W'(count_ff));
   assign sts.ptr_first = (ptr_ff == '0);
   assign sts.ptr_end   = (ptr_ff == count_ff);

   // read address select
   always_comb begin
      case (cmd.rd_sel)
         RD_HEAD: raddr_w = head_idx_w[ADDR_W-1:0];
         RD_DEL:  raddr_w = del_idx_w[ADDR_W-1:0];
         RD_PTR:  raddr_w = ptr_ff[ADDR_W-1:0];
         default: raddr_w = ptr_ff[ADDR_W-1:0];
      endcase
   end

   // write port: push at the top or close-up copy
   assign wr_en_w = cmd.wr_push | cmd.wr_shift;
   assign waddr_w = cmd.wr_push ? count_ff[ADDR_W-1:0] : dst_ff;
   assign wdata_w = cmd.wr_push ? value_ff : rdata_ff;

   // memory with registered read
   always_ff @(posedge clock) begin
      if (wr_en_w) begin
         entries_ff[waddr_w] <= wdata_w;
      end
      if (cmd.rd_en) begin
         rdata_ff <= entries_ff[raddr_w];
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         kind_ff     <= req_kind;
         value_ff    <= req_value;
         position_ff <= req_position;
      end
   end

   // count and pointer next values
   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_clr) begin
         count_in = '0;
      end else if (cmd.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CNT_W'(1);
      end

      ptr_in = ptr_ff;
      dst_in = dst_ff;
      if (cmd.ptr_zero) begin
         ptr_in = '0;
      end else if (cmd.ptr_del) begin
         ptr_in = del_idx_w + CNT_W'(1);
         dst_in = del_idx_w[ADDR_W-1:0];
      end else if (cmd.ptr_inc) begin
         ptr_in = ptr_ff + CNT_W'(1);
      end
      if (cmd.wr_shift) begin
         dst_in = dst_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      dst_ff <= dst_in;
   end

   // working result: cleared on start, loaded with the read data for pop and delete, summed or compared during a walk
   always_comb begin
      res_in    = res_ff;
      found_in  = found_ff;
      status_in = status_ff;
      if (cmd.start) begin
         res_in    = '0;
         found_in  = 1'b0;
         status_in = cmd.status;
      end else if (cmd.take_rdata) begin
         res_in = rdata_ff;
      end else if (cmd.acc_en) begin
         if (kind_ff == KIND_SUM) begin
            res_in = res_ff + rdata_ff;
         end
         if (kind_ff == KIND_SEARCH && rdata_ff == value_ff) begin
            found_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      res_ff    <= res_in;
      found_ff  <= found_in;
      status_ff <= status_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_value_ff  <= res_ff;
         out_found_ff  <= found_ff;
         out_status_ff <= status_ff;
         out_count_ff  <= OUT_CNT_W'(count_ff);
      end
   end

   assign rsp_result_value = out_value_ff;
   assign rsp_found        = out_found_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_entry_count  = out_count_ff;

endmodule

`default_nettype wire

>>> rtl/core/bls_controller.sv
// controller: sequences each request through decode, memory walk and response hand-off
`timescale 1ns / 1ps
`default_nettype none

module bls_controller (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire bls_pkg::dp_sts_type  sts,
   output bls_pkg::dp_cmd_type       cmd
);
   import bls_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.status = ST_OK;
      cmd.rd_sel = RD_PTR;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_DECODE;
            end
         end

         S_DECODE: begin
            cmd.start = 1'b1;
            state_in  = S_FINISH;
            case (sts.kind)
               KIND_PUSH: begin
                  if (sts.full) begin
                     cmd.status = ST_FULL;
                  end else begin
                     cmd.wr_push = 1'b1;
                     cmd.cnt_inc = 1'b1;
                  end
               end
               KIND_POP: begin
                  if (sts.empty) begin
                     cmd.status = ST_EMPTY;
                  end else begin
                     cmd.rd_en   = 1'b1;
                     cmd.rd_sel  = RD_HEAD;
                     cmd.cnt_dec = 1'b1;
                     state_in    = S_POP_TAKE;
                  end
               end
               KIND_SEARCH, KIND_SUM: begin
                  if (!sts.empty) begin
                     cmd.ptr_zero = 1'b1;
                     state_in     = S_SCAN;
                  end
               end
               KIND_CLEAR: begin
                  cmd.cnt_clr = 1'b1;
               end
               KIND_DELETE: begin
                  if (sts.empty) begin
                     cmd.status = ST_EMPTY;
                  end else if (sts.pos_bad) begin
                     cmd.status = ST_RANGE;
                  end else begin
                     cmd.rd_en   = 1'b1;
                     cmd.rd_sel  = RD_DEL;
                     cmd.ptr_del = 1'b1;
                     state_in    = S_DEL_HEAD;
                  end
               end
               default: begin
                  // unused kinds answer ok with zeros
               end
            endcase
         end

         S_POP_TAKE: begin
            cmd.take_rdata = 1'b1;
            state_in       = S_FINISH;
         end

         // one read per cycle, each word folded in the cycle after its read
         S_SCAN: begin
            cmd.acc_en = !sts.ptr_first;
            if (sts.ptr_end) begin
               state_in = S_FINISH;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.ptr_inc = 1'b1;
            end
         end

         S_DEL_HEAD: begin
            cmd.take_rdata = 1'b1;
            if (sts.ptr_end) begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_FINISH;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.ptr_inc = 1'b1;
               state_in    = S_DEL_SHIFT;
            end
         end

         // each entry above the deleted one moves down by one
         S_DEL_SHIFT: begin
            cmd.wr_shift = 1'b1;
            if (sts.ptr_end) begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_FINISH;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.ptr_inc = 1'b1;
            end
         end

         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response valid flag
   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire
